[src/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define QPD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define QPD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/qpd_pkg.sv]
// Package: types, character constants and helpers of the quoted-printable decoder.
package qpd_pkg;

   localparam logic [7:0] CHAR_EOL = 8'h00;
   localparam logic [7:0] CHAR_EQ  = 8'h3D;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_0   = 8'h30;
   localparam logic [7:0] CHAR_9   = 8'h39;
   localparam logic [7:0] CHAR_A   = 8'h41;
   localparam logic [7:0] CHAR_F   = 8'h46;

   localparam int unsigned MAX_RESULTS = 3;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_HARD = 2'd1,
      KIND_SOFT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_EQ    = 2'd1,
      PHASE_DIGIT = 2'd2
   } phase_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_byte;
   } result_type;

   // Results caused by one character, slot 0 first.
   typedef struct packed {
      logic [1:0]                       count;
      result_type [MAX_RESULTS-1:0]     slot;
   } decode_type;

   // Hex digit check: bit 4 set for an upper-case hex digit, bits 3:0 its value.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] diff;
      diff = 8'h00;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         diff = c - CHAR_0;
         return {1'b1, diff[3:0]};
      end else if (c >= CHAR_A && c <= CHAR_F) begin
         diff = c - CHAR_A + 8'd10;
         return {1'b1, diff[3:0]};
      end
      return 5'b0_0000;
   endfunction

endpackage

[src/qpd_ifs.sv]
// Valid/ready channel interfaces for characters in and decoded results out.
interface qpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface qpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output kind, output out_byte, output last, input ready);
   modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

[src/qpd_decode.sv]
// Escape state machine and per-character decode into up to three results.
module qpd_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           char_code,
   output qpd_pkg::decode_type  dec
);

   qpd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         first_ff, first_in;
   logic [4:0]         hex_c, hex_first;
   logic               is_eol;

   assign hex_c     = qpd_pkg::hex_digit(char_code);
   assign hex_first = qpd_pkg::hex_digit(first_ff);
   assign is_eol    = (char_code == qpd_pkg::CHAR_EOL);

   // Next state.
   always_comb begin
      phase_in = phase_ff;
      first_in = first_ff;
      if (accept) begin
         phase_in = qpd_pkg::PHASE_IDLE;
         unique case (phase_ff)
            qpd_pkg::PHASE_EQ: begin
               if (!is_eol && hex_c[4]) begin
                  phase_in = qpd_pkg::PHASE_DIGIT;
                  first_in = char_code;
               end
            end
            qpd_pkg::PHASE_DIGIT: begin
               phase_in = qpd_pkg::PHASE_IDLE;
            end
            default: begin
               if (char_code == qpd_pkg::CHAR_EQ) begin
                  phase_in = qpd_pkg::PHASE_EQ;
               end
            end
         endcase
      end
   end

   // Results for the current character.
   always_comb begin
      dec = '0;
      unique case (phase_ff)
         qpd_pkg::PHASE_EQ: begin
            if (is_eol) begin
               dec.count   = 2'd1;
               dec.slot[0] = '{kind: qpd_pkg::KIND_SOFT, out_byte: 8'h00};
            end else if (!hex_c[4]) begin
               dec.count   = 2'd2;
               dec.slot[0] = '{kind: qpd_pkg::KIND_DATA, out_byte: qpd_pkg::CHAR_EQ};
               dec.slot[1] = '{kind: qpd_pkg::KIND_DATA, out_byte: char_code};
            end
         end
         qpd_pkg::PHASE_DIGIT: begin
            if (is_eol) begin
               dec.count   = 2'd3;
               dec.slot[0] = '{kind: qpd_pkg::KIND_DATA, out_byte: qpd_pkg::CHAR_EQ};
               dec.slot[1] = '{kind: qpd_pkg::KIND_DATA, out_byte: first_ff};
               dec.slot[2] = '{kind: qpd_pkg::KIND_HARD, out_byte: 8'h00};
            end else if (hex_c[4]) begin
               // drop a decoded carriage return
               if ({hex_first[3:0], hex_c[3:0]} != qpd_pkg::CHAR_CR) begin
                  dec.count   = 2'd1;
                  dec.slot[0] = '{kind: qpd_pkg::KIND_DATA,
                                  out_byte: {hex_first[3:0], hex_c[3:0]}};
               end
            end else begin
               dec.count   = 2'd3;
               dec.slot[0] = '{kind: qpd_pkg::KIND_DATA, out_byte: qpd_pkg::CHAR_EQ};
               dec.slot[1] = '{kind: qpd_pkg::KIND_DATA, out_byte: first_ff};
               dec.slot[2] = '{kind: qpd_pkg::KIND_DATA, out_byte: char_code};
            end
         end
         default: begin
            if (is_eol) begin
               dec.count   = 2'd1;
               dec.slot[0] = '{kind: qpd_pkg::KIND_HARD, out_byte: 8'h00};
            end else if (char_code != qpd_pkg::CHAR_EQ) begin
               dec.count   = 2'd1;
               dec.slot[0] = '{kind: qpd_pkg::KIND_DATA, out_byte: char_code};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= qpd_pkg::PHASE_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
   end

endmodule

[src/qpd_emit.sv]
// Result register: holds up to three results, gives one per cycle while ready.
module qpd_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  qpd_pkg::decode_type  dec,
   input  logic                 out_ready,
   output logic                 out_valid,
   output qpd_pkg::result_type  out_result,
   output logic                 out_last,
   output logic                 free
);

   logic [1:0]                                   count_ff, count_in;
   qpd_pkg::result_type [qpd_pkg::MAX_RESULTS-1:0] slot_ff, slot_in;
   logic                                         pop;

   assign out_valid  = (count_ff != 2'd0);
   assign out_result = slot_ff[0];
   assign out_last   = (count_ff == 2'd1);
   assign pop        = out_valid && out_ready;
   assign free       = !out_valid || (pop && out_last);

   always_comb begin
      count_in = count_ff;
      slot_in  = slot_ff;
      if (load) begin
         count_in = dec.count;
         slot_in  = dec.slot;
      end else if (pop) begin
         // advance the queue by one
         count_in   = count_ff - 2'd1;
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

[src/quoted_printable_decoder_top.sv]
// Top level of the quoted-printable decoder.
// An accepted character's results are registered and show from the next cycle on.
// Throughput: one character per cycle when it makes at most one result and the
//   receiver is ready; a character that makes two or three results holds the input.
// The result register sets the rate: it takes a character when empty or giving its last.
// Reset (synchronous, active high) leaves the escape and drops pending results.
`include "assert_macros.svh"

module quoted_printable_decoder_top (
   input  logic        clock,
   input  logic        reset,
   qpd_req_if.sink     req_ch,
   qpd_rsp_if.source   rsp_ch
);

   qpd_pkg::decode_type dec;
   qpd_pkg::result_type result;
   logic                free;
   logic                req_accept;

   // Take a transaction whenever the result register is empty or empties in this cycle,
   // so a new character can land right behind the last result of the previous one.
   assign req_ch.ready = free;
   assign req_accept   = req_ch.valid && free;

   // Decode the incoming character against the current escape state; the
   // state advances only on an accepted transaction.
   qpd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .char_code (req_ch.char_code),
      .dec       (dec)
   );

   // Hold the results of one character and drain them in order.
   qpd_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept),
      .dec        (dec),
      .out_ready  (rsp_ch.ready),
      .out_valid  (rsp_ch.valid),
      .out_result (result),
      .out_last   (rsp_ch.last),
      .free       (free)
   );

   assign rsp_ch.kind     = result.kind;
   assign rsp_ch.out_byte = result.out_byte;

   // A new character may only enter when no result but the one leaving now is pending.
   `QPD_ASSERT_NOW(a_accept_when_drained, req_accept, !rsp_ch.valid || (rsp_ch.ready && rsp_ch.last), "character accepted over pending results")
   // Line ends always close the results of their character.
   `QPD_ASSERT_NOW(a_line_end_last, rsp_ch.valid && (result.kind != qpd_pkg::KIND_DATA), rsp_ch.last, "line end not marked last")
   // Results of one character come out without a gap.
   `QPD_ASSERT_NEXT(a_no_gap, rsp_ch.valid && rsp_ch.ready && !rsp_ch.last, rsp_ch.valid, "gap inside results of one character")

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the quoted-printable decoder top level.
`timescale 1ns / 100ps

module tb_top;

   // Cycles without any transaction before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 1000;
   // Receiver hold-off: when it starts (in characters sent) and how long it lasts.
   localparam int HOLD_AT        = 60;
   localparam int HOLD_CYCLES    = 80;
   // Number of trailing characters sent with no idling on either side.
   localparam int STEADY_TAIL    = 30;
   localparam int RANDOM_ITEMS   = 200;

   // One expected decoder output, with the end-of-character flag.
   typedef struct packed {
      qpd_pkg::kind_type kind;
      logic [7:0]        out_byte;
      logic              last;
   } decoded_entry_type;

   // One character of stimulus; pinned_n >= 0 means the results are typed in.
   typedef struct {
      logic [7:0]          chr;
      int                  pinned_n;
      qpd_pkg::result_type pinned [3];
   } text_row_type;

   logic clock = 1'b0;
   logic reset;

   qpd_req_if req_ch ();
   qpd_rsp_if rsp_ch ();

   quoted_printable_decoder_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // 8 ns period: 4 ns high, 4 ns low.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   text_row_type      text_rows [$];
   decoded_entry_type pending_results [$];
   int                directed_count;
   int                sent_count  = 0;
   int                error_count = 0;
   int                idle_cycles = 0;
   bit                steady      = 1'b0;
   bit                hold_done   = 1'b0;

   // ---------------------------------------------------------------
   // Decoder prediction: escape phase and the held first digit.
   // ---------------------------------------------------------------
   qpd_pkg::phase_type  esc_phase  = qpd_pkg::PHASE_IDLE;
   logic [7:0]          held_digit = 8'h00;
   qpd_pkg::result_type decoded [3];
   int                  emit_count;

   function automatic bit is_hex(input logic [7:0] c);
      return (c >= qpd_pkg::CHAR_0 && c <= qpd_pkg::CHAR_9) ||
             (c >= qpd_pkg::CHAR_A && c <= qpd_pkg::CHAR_F);
   endfunction

   // Nibble value of a character already known to be a hex digit.
   function automatic logic [3:0] nibble(input logic [7:0] c);
      return (c <= qpd_pkg::CHAR_9) ? c[3:0] : c[3:0] + 4'd9;
   endfunction

   function automatic void emit(input qpd_pkg::kind_type k, input logic [7:0] b);
      decoded[emit_count] = {k, b};
      emit_count++;
   endfunction

   // Advance the predicted state by one character; return the number of results.
   function automatic int decode_char(input logic [7:0] c);
      logic [7:0] value;
      emit_count = 0;
      unique case (esc_phase)
         qpd_pkg::PHASE_EQ: begin
            esc_phase = qpd_pkg::PHASE_IDLE;
            if (c == qpd_pkg::CHAR_EOL) begin
               emit(qpd_pkg::KIND_SOFT, 8'h00);
            end else if (is_hex(c)) begin
               held_digit = c;
               esc_phase  = qpd_pkg::PHASE_DIGIT;
            end else begin
               emit(qpd_pkg::KIND_DATA, qpd_pkg::CHAR_EQ);
               emit(qpd_pkg::KIND_DATA, c);
            end
         end
         qpd_pkg::PHASE_DIGIT: begin
            esc_phase = qpd_pkg::PHASE_IDLE;
            if (c == qpd_pkg::CHAR_EOL) begin
               emit(qpd_pkg::KIND_DATA, qpd_pkg::CHAR_EQ);
               emit(qpd_pkg::KIND_DATA, held_digit);
               emit(qpd_pkg::KIND_HARD, 8'h00);
            end else if (is_hex(c)) begin
               value = {nibble(held_digit), nibble(c)};
               // A decoded carriage return vanishes.
               if (value != qpd_pkg::CHAR_CR) emit(qpd_pkg::KIND_DATA, value);
            end else begin
               emit(qpd_pkg::KIND_DATA, qpd_pkg::CHAR_EQ);
               emit(qpd_pkg::KIND_DATA, held_digit);
               emit(qpd_pkg::KIND_DATA, c);
            end
         end
         default: begin
            esc_phase = qpd_pkg::PHASE_IDLE;
            if (c == qpd_pkg::CHAR_EOL) emit(qpd_pkg::KIND_HARD, 8'h00);
            else if (c == qpd_pkg::CHAR_EQ) esc_phase = qpd_pkg::PHASE_EQ;
            else emit(qpd_pkg::KIND_DATA, c);
         end
      endcase
      return emit_count;
   endfunction

   // Queue the results of one accepted character: typed-in ones where pinned,
   // else the predicted ones. The predictor always runs to keep its state.
   task automatic queue_expected(input text_row_type r);
      int                n;
      decoded_entry_type e;
      n = decode_char(r.chr);
      if (r.pinned_n >= 0) begin
         n = r.pinned_n;
         for (int k = 0; k < n; k++) decoded[k] = r.pinned[k];
      end
      for (int k = 0; k < n; k++) begin
         e.kind     = decoded[k].kind;
         e.out_byte = decoded[k].out_byte;
         e.last     = (k == n - 1);
         pending_results.push_back(e);
      end
   endtask

   // ---------------------------------------------------------------
   // Stimulus construction.
   // ---------------------------------------------------------------
   task automatic row(input logic [7:0] c, input int n = -1,
                      input qpd_pkg::result_type r0 = '0,
                      input qpd_pkg::result_type r1 = '0,
                      input qpd_pkg::result_type r2 = '0);
      text_row_type r;
      r.chr       = c;
      r.pinned_n  = n;
      r.pinned[0] = r0;
      r.pinned[1] = r1;
      r.pinned[2] = r2;
      text_rows.push_back(r);
   endtask

   function automatic logic [7:0] random_hex();
      int idx;
      idx = $urandom_range(0, 15);
      return (idx < 10) ? qpd_pkg::CHAR_0 + 8'(idx) : qpd_pkg::CHAR_A + 8'(idx - 10);
   endfunction

   // Any nonzero character that is not an upper-case hex digit, '=' included.
   function automatic logic [7:0] random_non_hex();
      logic [7:0] c;
      c = 8'($urandom_range(1, 255));
      while (is_hex(c)) c = 8'($urandom_range(1, 255));
      return c;
   endfunction

   // Well-formed and malformed escapes with random content, plus plain text and noise.
   task automatic add_random_text(input int count);
      int         start;
      logic [7:0] c;
      start = text_rows.size();
      while (text_rows.size() - start < count) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               c = 8'($urandom_range(1, 255));
               if (c == qpd_pkg::CHAR_EQ) c = 8'h3C;
               row(c);
            end
            3: row(qpd_pkg::CHAR_EOL);
            4, 5: begin
               row(qpd_pkg::CHAR_EQ);
               row(random_hex());
               row(random_hex());
            end
            6: begin
               row(qpd_pkg::CHAR_EQ);
               row(qpd_pkg::CHAR_EOL);
            end
            7: begin
               row(qpd_pkg::CHAR_EQ);
               row(random_non_hex());
            end
            8: begin
               row(qpd_pkg::CHAR_EQ);
               row(random_hex());
               row($urandom_range(0, 1) ? qpd_pkg::CHAR_EOL : random_non_hex());
            end
            default: row(8'($urandom_range(0, 255)));
         endcase
      end
   endtask

   // ---------------------------------------------------------------
   // Sender: reset, directed table, drain pause, random text, final check.
   // ---------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.char_code  = 8'h00;

      // Directed table, starting from the reset state.
      row(qpd_pkg::CHAR_EOL, 1, {qpd_pkg::KIND_HARD, 8'h00});   // line end outside escape
      row(8'hFF, 1, {qpd_pkg::KIND_DATA, 8'hFF});               // top byte passes through
      row(8'h01, 1, {qpd_pkg::KIND_DATA, 8'h01});               // lowest plain byte
      row(qpd_pkg::CHAR_EQ, 0);                                 // soft line end
      row(qpd_pkg::CHAR_EOL, 1, {qpd_pkg::KIND_SOFT, 8'h00});
      row(qpd_pkg::CHAR_EQ);                                    // =A0
      row(qpd_pkg::CHAR_A);
      row(qpd_pkg::CHAR_0);
      row(qpd_pkg::CHAR_EQ);                                    // =FF, top digits
      row(qpd_pkg::CHAR_F);
      row(qpd_pkg::CHAR_F);
      row(qpd_pkg::CHAR_EQ, 0);                                 // =0D is dropped
      row(qpd_pkg::CHAR_0, 0);
      row(8'h44, 0);
      row(qpd_pkg::CHAR_EQ, 0);                                 // lower-case is not hex
      row(8'h61, 2, {qpd_pkg::KIND_DATA, qpd_pkg::CHAR_EQ}, {qpd_pkg::KIND_DATA, 8'h61});
      row(qpd_pkg::CHAR_EQ, 0);                                 // == opens no new escape
      row(qpd_pkg::CHAR_EQ, 2, {qpd_pkg::KIND_DATA, qpd_pkg::CHAR_EQ},
          {qpd_pkg::KIND_DATA, qpd_pkg::CHAR_EQ});
      row(8'h5A, 1, {qpd_pkg::KIND_DATA, 8'h5A});
      row(qpd_pkg::CHAR_EQ, 0);                                 // =9 then line end
      row(qpd_pkg::CHAR_9, 0);
      row(qpd_pkg::CHAR_EOL, 3, {qpd_pkg::KIND_DATA, qpd_pkg::CHAR_EQ},
          {qpd_pkg::KIND_DATA, qpd_pkg::CHAR_9}, {qpd_pkg::KIND_HARD, 8'h00});
      row(qpd_pkg::CHAR_EQ, 0);                                 // =5 then non-hex
      row(8'h35, 0);
      row(8'h47, 3, {qpd_pkg::KIND_DATA, qpd_pkg::CHAR_EQ},
          {qpd_pkg::KIND_DATA, 8'h35}, {qpd_pkg::KIND_DATA, 8'h47});
      directed_count = text_rows.size();
      add_random_text(RANDOM_ITEMS);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < text_rows.size(); i++) begin
         steady = (i >= text_rows.size() - STEADY_TAIL);
         if (i == directed_count) begin
            // Drop valid and let every pending result drain before the random text.
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (pending_results.size() != 0) @(posedge clock);
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            // Idle burst on the sender side.
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         req_ch.valid     <= 1'b1;
         req_ch.char_code <= text_rows[i].chr;
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
         // The character transaction completed at this edge.
         queue_expected(text_rows[i]);
         sent_count++;
      end
      req_ch.valid <= 1'b0;

      // Wait out the remaining results, then idle on for strays before the final check.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------
   // Receiver: ready in random stretches, one long hold-off, none at the end.
   // ---------------------------------------------------------------
   initial begin
      int stretch;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (!hold_done && sent_count >= HOLD_AT) begin
            // Hold off long enough for the decoder to fill and stall its input.
            hold_done    = 1'b1;
            rsp_ch.ready <= 1'b0;
            stretch      = HOLD_CYCLES;
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            stretch      = $urandom_range(1, 5);
         end else begin
            rsp_ch.ready <= 1'b1;
            stretch      = $urandom_range(1, 8);
         end
         repeat (stretch) @(posedge clock);
      end
   end

   // ---------------------------------------------------------------
   // Result checker: compare each result transaction with the oldest expectation.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      decoded_entry_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result: expected none, actual kind %0d byte %02h last %0b",
                     $time, rsp_ch.kind, rsp_ch.out_byte, rsp_ch.last);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.kind !== want.kind) begin
               error_count++;
               $display("%0t: kind mismatch: expected %0d, actual %0d",
                        $time, want.kind, rsp_ch.kind);
            end
            if (rsp_ch.out_byte !== want.out_byte) begin
               error_count++;
               $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                        $time, want.out_byte, rsp_ch.out_byte);
            end
            if (rsp_ch.last !== want.last) begin
               error_count++;
               $display("%0t: last mismatch: expected %0b, actual %0b",
                        $time, want.last, rsp_ch.last);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Watchdog: end the run when no transaction happens for too long.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

endmodule
